>>> rtl/egsv_pkg.sv
// Shared constants, types and helpers for the ElGamal signature checker.
`timescale 1ns / 1ps

package egsv_pkg;

   // Modulus width and number of message bytes.
   localparam int MOD_W     = 14;
   localparam int MSG_BYTES = 6;

   // Fixed widths of the item fields.
   localparam int FIELD_W = 14;
   localparam int GEN_W   = 10;
   localparam int BYTE_W  = 8;
   localparam int TEXT_W  = BYTE_W * MSG_BYTES;

   // Decimal-style fold base and the smallest usable modulus.
   localparam int DEC_BASE = 100;
   localparam int P_MIN    = 2;

   // Each byte adds less than seven bits after the first one.
   localparam int MSG_W = 7 * MSG_BYTES + 2;

   // The reduction shifter takes the message, the generator or r.
   localparam int RED_W = (MSG_W > FIELD_W) ? MSG_W : FIELD_W;

   // Exponents are the raw 14-bit fields or the hash.
   localparam int EXP_W = (MOD_W > FIELD_W) ? MOD_W : FIELD_W;

   // Multiplier step width: holds 2*acc + x, which stays below 3p.
   localparam int MUL_W = MOD_W + 2;

   // Counter widths.
   localparam int FOLD_CNT_W = $clog2(MSG_BYTES + 1);
   localparam int RED_CNT_W  = $clog2(RED_W);
   localparam int MUL_CNT_W  = $clog2(MOD_W);

   // Steps of the verification program, in the order they run.
   typedef enum logic [3:0] {
      OP_RED_M  = 4'd0,
      OP_HASH   = 4'd1,
      OP_RED_G  = 4'd2,
      OP_RED_R  = 4'd3,
      OP_POW_Y  = 4'd4,
      OP_POW_L  = 4'd5,
      OP_POW_YR = 4'd6,
      OP_POW_RS = 4'd7,
      OP_RHS    = 4'd8
   } op_type;

   // Operand pair and destination of one modular multiplication.
   typedef enum logic [1:0] {
      MSRC_HASH = 2'd0,
      MSRC_RHS  = 2'd1,
      MSRC_ACC  = 2'd2,
      MSRC_SQ   = 2'd3
   } mul_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        fold;
      logic        red_start;
      logic        mul_start;
      mul_src_type mul_src;
      logic        pow_start;
      logic        exp_shift;
      logic        pow_write;
      logic        finish;
      op_type      op;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bad;
      logic fold_last;
      logic busy;
      logic exp_zero;
      logic exp_lsb;
   } dp_status_type;

   // Program step that follows a given one.
   function automatic op_type next_op(input op_type op);
      op_type nxt;
      case (op)
         OP_RED_M:  nxt = OP_HASH;
         OP_HASH:   nxt = OP_RED_G;
         OP_RED_G:  nxt = OP_RED_R;
         OP_RED_R:  nxt = OP_POW_Y;
         OP_POW_Y:  nxt = OP_POW_L;
         OP_POW_L:  nxt = OP_POW_YR;
         OP_POW_YR: nxt = OP_POW_RS;
         OP_POW_RS: nxt = OP_RHS;
         default:   nxt = OP_RHS;
      endcase
      return nxt;
   endfunction

endpackage

>>> rtl/egsv_datapath.sv
// Datapath of the signature checker: fold, bit-serial reduction, modular multiplier, exponent.
`timescale 1ns / 1ps

module egsv_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  egsv_pkg::ctrl_cmd_type          cmd,
   output egsv_pkg::dp_status_type         status,
   input  logic [egsv_pkg::FIELD_W-1:0]    in_key_exponent,
   input  logic [egsv_pkg::FIELD_W-1:0]    in_sig_s,
   input  logic [egsv_pkg::FIELD_W-1:0]    in_sig_r,
   input  logic [egsv_pkg::FIELD_W-1:0]    in_modulus_p,
   input  logic [egsv_pkg::GEN_W-1:0]      in_generator_g,
   input  logic [egsv_pkg::TEXT_W-1:0]     in_date_text,
   output logic                            res_valid_res,
   output logic [egsv_pkg::FIELD_W-1:0]    res_hash_value
);
   import egsv_pkg::*;

   // Captured item fields.
   logic [MOD_W-1:0]      p_ff, p_in;
   logic [FIELD_W-1:0]    a_ff, a_in, s_ff, s_in, r_raw_ff, r_raw_in;
   logic [GEN_W-1:0]      g_raw_ff, g_raw_in;
   logic [TEXT_W-1:0]     text_ff, text_in;

   // Message fold.
   logic [MSG_W-1:0]      m_ff, m_in;
   logic [FOLD_CNT_W-1:0] fold_cnt_ff, fold_cnt_in;

   // Bit-serial reduction unit.
   logic [RED_W-1:0]      rval_ff, rval_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;
   logic [RED_CNT_W-1:0]  rcnt_ff, rcnt_in;
   logic                  red_busy_ff, red_busy_in;

   // Interleaved modular multiplier.
   logic [MOD_W-1:0]      mx_ff, mx_in, my_ff, my_in, macc_ff, macc_in;
   logic [MUL_CNT_W-1:0]  mcnt_ff, mcnt_in;
   logic                  mul_busy_ff, mul_busy_in;
   mul_src_type           msrc_ff, msrc_in;

   // Exponentiation registers.
   logic [MOD_W-1:0]      acc_ff, acc_in, base_ff, base_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;

   // Intermediate values of the check.
   logic [MOD_W-1:0]      mr_ff, mr_in, h_ff, h_in, gr_ff, gr_in, rr_ff, rr_in;
   logic [MOD_W-1:0]      y_ff, y_in, lhs_ff, lhs_in, yr_ff, yr_in, rs_ff, rs_in;
   logic [MOD_W-1:0]      rhs_ff, rhs_in;

   // Result registers.
   logic                  res_valid_ff, res_valid_in;
   logic [FIELD_W-1:0]    res_hash_ff, res_hash_in;

   // Combinational step values.
   logic [MOD_W:0]        red_t;
   logic [MOD_W-1:0]      rem_next;
   logic [MUL_W-1:0]      mul_t, mul_p1, mul_p2;
   logic [MOD_W-1:0]      mul_add, macc_next;
   logic                  bad;

   assign bad = (p_ff < MOD_W'(P_MIN));

   // One reduction step: shift in the next bit and subtract p once if needed.
   always_comb begin
      red_t = {rem_ff, rval_ff[RED_W-1]};
      if (red_t >= {1'b0, p_ff}) begin
         rem_next = MOD_W'(red_t - {1'b0, p_ff});
      end else begin
         rem_next = MOD_W'(red_t);
      end
   end

   // One multiplier step: 2*acc plus x or zero stays below 3p, so pick among t, t-p, t-2p.
   always_comb begin
      mul_add = my_ff[MOD_W-1] ? mx_ff : '0;
      mul_t   = (MUL_W'(macc_ff) << 1) + MUL_W'(mul_add);
      mul_p1  = MUL_W'(p_ff);
      mul_p2  = MUL_W'(p_ff) << 1;
      if (mul_t >= mul_p2) begin
         macc_next = MOD_W'(mul_t - mul_p2);
      end else if (mul_t >= mul_p1) begin
         macc_next = MOD_W'(mul_t - mul_p1);
      end else begin
         macc_next = MOD_W'(mul_t);
      end
   end

   // Next-state logic of all datapath registers under controller commands.
   always_comb begin
      p_in         = p_ff;
      a_in         = a_ff;
      s_in         = s_ff;
      r_raw_in     = r_raw_ff;
      g_raw_in     = g_raw_ff;
      text_in      = text_ff;
      m_in         = m_ff;
      fold_cnt_in  = fold_cnt_ff;
      rval_in      = rval_ff;
      rem_in       = rem_ff;
      rcnt_in      = rcnt_ff;
      red_busy_in  = red_busy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      macc_in      = macc_ff;
      mcnt_in      = mcnt_ff;
      mul_busy_in  = mul_busy_ff;
      msrc_in      = msrc_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mr_in        = mr_ff;
      h_in         = h_ff;
      gr_in        = gr_ff;
      rr_in        = rr_ff;
      y_in         = y_ff;
      lhs_in       = lhs_ff;
      yr_in        = yr_ff;
      rs_in        = rs_ff;
      rhs_in       = rhs_ff;
      res_valid_in = res_valid_ff;
      res_hash_in  = res_hash_ff;

      // Capture a new item.
      if (cmd.load) begin
         p_in        = MOD_W'(in_modulus_p);
         a_in        = in_key_exponent;
         s_in        = in_sig_s;
         r_raw_in    = in_sig_r;
         g_raw_in    = in_generator_g;
         text_in     = in_date_text;
         m_in        = '0;
         fold_cnt_in = '0;
      end

      // Fold one message byte, first byte first.
      if (cmd.fold) begin
         m_in        = MSG_W'(m_ff * MSG_W'(DEC_BASE)) + MSG_W'(text_ff[TEXT_W-1 -: BYTE_W]);
         text_in     = text_ff << BYTE_W;
         fold_cnt_in = fold_cnt_ff + FOLD_CNT_W'(1);
      end

      // Reduction unit: start, then one bit per cycle, writing the remainder at the end.
      if (cmd.red_start) begin
         case (cmd.op)
            OP_RED_M: rval_in = RED_W'(m_ff);
            OP_RED_G: rval_in = RED_W'(g_raw_ff);
            default:  rval_in = RED_W'(r_raw_ff);
         endcase
         rem_in      = '0;
         rcnt_in     = RED_CNT_W'(RED_W - 1);
         red_busy_in = 1'b1;
      end else if (red_busy_ff) begin
         rem_in  = rem_next;
         rval_in = rval_ff << 1;
         rcnt_in = rcnt_ff - RED_CNT_W'(1);
         if (rcnt_ff == '0) begin
            red_busy_in = 1'b0;
            case (cmd.op)
               OP_RED_M: mr_in = rem_next;
               OP_RED_G: gr_in = rem_next;
               default:  rr_in = rem_next;
            endcase
         end
      end

      // Multiplier: start with an operand pair, then one bit of y per cycle.
      if (cmd.mul_start) begin
         case (cmd.mul_src)
            MSRC_HASH: begin
               mx_in = mr_ff;
               my_in = mr_ff;
            end
            MSRC_RHS: begin
               mx_in = yr_ff;
               my_in = rs_ff;
            end
            MSRC_ACC: begin
               mx_in = acc_ff;
               my_in = base_ff;
            end
            default: begin
               mx_in = base_ff;
               my_in = base_ff;
            end
         endcase
         macc_in     = '0;
         mcnt_in     = MUL_CNT_W'(MOD_W - 1);
         mul_busy_in = 1'b1;
         msrc_in     = cmd.mul_src;
      end else if (mul_busy_ff) begin
         macc_in = macc_next;
         my_in   = my_ff << 1;
         mcnt_in = mcnt_ff - MUL_CNT_W'(1);
         if (mcnt_ff == '0) begin
            mul_busy_in = 1'b0;
            case (msrc_ff)
               MSRC_HASH: h_in    = macc_next;
               MSRC_RHS:  rhs_in  = macc_next;
               MSRC_ACC:  acc_in  = macc_next;
               default:   base_in = macc_next;
            endcase
         end
      end

      // Exponentiation setup: the accumulator starts at one, which is below any valid p.
      if (cmd.pow_start) begin
         acc_in = MOD_W'(1);
         case (cmd.op)
            OP_POW_Y: begin
               base_in = gr_ff;
               exp_in  = EXP_W'(a_ff);
            end
            OP_POW_L: begin
               base_in = gr_ff;
               exp_in  = EXP_W'(h_ff);
            end
            OP_POW_YR: begin
               base_in = y_ff;
               exp_in  = EXP_W'(r_raw_ff);
            end
            default: begin
               base_in = rr_ff;
               exp_in  = EXP_W'(s_ff);
            end
         endcase
      end

      if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end

      // Store the finished power.
      if (cmd.pow_write) begin
         case (cmd.op)
            OP_POW_Y:  y_in   = acc_ff;
            OP_POW_L:  lhs_in = acc_ff;
            OP_POW_YR: yr_in  = acc_ff;
            default:   rs_in  = acc_ff;
         endcase
      end

      // Latch the result item; a modulus below two gives zeros.
      if (cmd.finish) begin
         res_valid_in = !bad && (lhs_ff == rhs_ff);
         res_hash_in  = bad ? '0 : FIELD_W'(h_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         red_busy_ff <= 1'b0;
         mul_busy_ff <= 1'b0;
      end else begin
         red_busy_ff <= red_busy_in;
         mul_busy_ff <= mul_busy_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      a_ff         <= a_in;
      s_ff         <= s_in;
      r_raw_ff     <= r_raw_in;
      g_raw_ff     <= g_raw_in;
      text_ff      <= text_in;
      m_ff         <= m_in;
      fold_cnt_ff  <= fold_cnt_in;
      rval_ff      <= rval_in;
      rem_ff       <= rem_in;
      rcnt_ff      <= rcnt_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      macc_ff      <= macc_in;
      mcnt_ff      <= mcnt_in;
      msrc_ff      <= msrc_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      mr_ff        <= mr_in;
      h_ff         <= h_in;
      gr_ff        <= gr_in;
      rr_ff        <= rr_in;
      y_ff         <= y_in;
      lhs_ff       <= lhs_in;
      yr_ff        <= yr_in;
      rs_ff        <= rs_in;
      rhs_ff       <= rhs_in;
      res_valid_ff <= res_valid_in;
      res_hash_ff  <= res_hash_in;
   end

   // Status to the controller.
   always_comb begin
      status.bad       = bad;
      status.fold_last = (fold_cnt_ff == FOLD_CNT_W'(MSG_BYTES - 1));
      status.busy      = red_busy_ff | mul_busy_ff;
      status.exp_zero  = (exp_ff == '0);
      status.exp_lsb   = exp_ff[0];
   end

   assign res_valid_res  = res_valid_ff;
   assign res_hash_value = res_hash_ff;

   // The multiplier accumulator stays reduced while it runs.
   a_macc_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_busy_ff |-> (macc_ff < p_ff))
      else $error("multiplier accumulator not below the modulus");

   // The reduction remainder stays reduced while it runs.
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      red_busy_ff |-> (rem_ff < p_ff))
      else $error("reduction remainder not below the modulus");

   // The two arithmetic units never run at the same time.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(red_busy_ff && mul_busy_ff))
      else $error("reduction and multiplier busy together");

endmodule

>>> rtl/egsv_ctrl.sv
// Controller state machine that sequences the verification program.
`timescale 1ns / 1ps

module egsv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output egsv_pkg::ctrl_cmd_type    cmd,
   input  egsv_pkg::dp_status_type   status
);
   import egsv_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_CHECK    = 9'b000000010,
      S_FOLD     = 9'b000000100,
      S_START    = 9'b000001000,
      S_WAIT     = 9'b000010000,
      S_POW_TEST = 9'b000100000,
      S_POW_ACC  = 9'b001000000,
      S_POW_SQ   = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cmd         = '0;
      cmd.op      = op_ff;
      cmd.mul_src = MSRC_HASH;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_RED_M;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = status.bad ? S_FINISH : S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (status.fold_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            case (op_ff)
               OP_RED_M, OP_RED_G, OP_RED_R: begin
                  cmd.red_start = 1'b1;
                  state_in      = S_WAIT;
               end
               OP_HASH: begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_src   = MSRC_HASH;
                  state_in      = S_WAIT;
               end
               OP_RHS: begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_src   = MSRC_RHS;
                  state_in      = S_WAIT;
               end
               default: begin
                  cmd.pow_start = 1'b1;
                  state_in      = S_POW_TEST;
               end
            endcase
         end
         S_WAIT: begin
            if (!status.busy) begin
               if (op_ff == OP_RHS) begin
                  state_in = S_FINISH;
               end else begin
                  op_in    = next_op(op_ff);
                  state_in = S_START;
               end
            end
         end
         // Right-to-left square and multiply, one exponent bit per pass.
         S_POW_TEST: begin
            if (status.exp_zero) begin
               cmd.pow_write = 1'b1;
               op_in         = next_op(op_ff);
               state_in      = S_START;
            end else if (status.exp_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = MSRC_ACC;
               state_in      = S_POW_ACC;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = MSRC_SQ;
               state_in      = S_POW_SQ;
            end
         end
         S_POW_ACC: begin
            if (!status.busy) begin
               cmd.mul_start = 1'b1;
               cmd.mul_src   = MSRC_SQ;
               state_in      = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            if (!status.busy) begin
               cmd.exp_shift = 1'b1;
               state_in      = S_POW_TEST;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: set when a result is latched, cleared when it is taken.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_RED_M;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted item always goes to the modulus check next.
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted item did not reach the modulus check");

   // A unit started from the dispatch state is busy when the wait begins.
   a_unit_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && $past(state_ff) == S_START) |-> status.busy)
      else $error("arithmetic unit idle right after start");

endmodule

>>> rtl/elgamal_signature_verify.sv
// ElGamal signature checker: verifies (r, s) over a small modulus and returns the hash.
//
// Usage: present one item on the req_ channel (key exponent a, signature r and s,
// modulus p, generator g and six message bytes) with req_valid; it is taken when
// req_valid and req_ready are both high. One result item (valid_res and hash_value)
// appears on the rsp_ channel and is taken when rsp_valid and rsp_ready are high.
// The block works on one item at a time; req_ready is high only while it is idle.
// One reduction unit shifts the message, g and r through bit by bit, and one
// interleaved modular multiplier does every product. Each of the four
// exponentiations runs a squaring for every exponent bit up to the highest set
// bit, plus a multiply for every set bit. A modulus below two skips the program
// and goes straight to the result.
// The result sits in an output register, so a new item may be accepted while the
// previous result waits; that item then holds at its end until the output is free.
// Reset (synchronous, active high) returns the controller to idle and drops rsp_valid.
`timescale 1ns / 1ps

module elgamal_signature_verify (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [egsv_pkg::FIELD_W-1:0]    req_key_exponent,
   input  logic [egsv_pkg::FIELD_W-1:0]    req_sig_s,
   input  logic [egsv_pkg::FIELD_W-1:0]    req_sig_r,
   input  logic [egsv_pkg::FIELD_W-1:0]    req_modulus_p,
   input  logic [egsv_pkg::GEN_W-1:0]      req_generator_g,
   input  logic [egsv_pkg::TEXT_W-1:0]     req_date_text,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_valid_res,
   output logic [egsv_pkg::FIELD_W-1:0]    rsp_hash_value
);
   import egsv_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer.
   egsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage.
   egsv_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_key_exponent (req_key_exponent),
      .in_sig_s        (req_sig_s),
      .in_sig_r        (req_sig_r),
      .in_modulus_p    (req_modulus_p),
      .in_generator_g  (req_generator_g),
      .in_date_text    (req_date_text),
      .res_valid_res   (rsp_valid_res),
      .res_hash_value  (rsp_hash_value)
   );

endmodule
